// ===== rtl/aeft_pkg.sv =====
// ----------------------------------------------------------------------------
// aeft_pkg
// Shared types, constants and helper functions for the encoder frequency
// tuner: request payloads, register indexes, accuracy levels and step table.
// ----------------------------------------------------------------------------
package aeft_pkg;

    // field widths
    localparam int COUNT_W = 8;
    localparam int TIME_W  = 32;
    localparam int LEVEL_W = 3;
    localparam int FREQ_W  = 33;
    localparam int AVG_W   = 10;
    localparam int HALF_W  = AVG_W - 1;

    // counter modulus, only its low bits matter after masking the delta
    localparam int COUNT_MODULUS = 256;
    localparam logic [COUNT_W-1:0] COUNT_MOD_LOW = COUNT_W'(COUNT_MODULUS);

    // timing constants in milliseconds
    localparam logic [TIME_W-1:0] TIME_CAP  = TIME_W'(500);
    localparam logic [AVG_W-1:0]  AVG_RESET = AVG_W'(128);
    localparam logic [AVG_W-1:0]  AVG_SLOW  = AVG_W'(256);

    // level thresholds on half of the average
    localparam logic [HALF_W-1:0] HALF_XFINE  = HALF_W'(64 * 2);
    localparam logic [HALF_W-1:0] HALF_FINE   = HALF_W'(64);
    localparam logic [HALF_W-1:0] HALF_MEDIUM = HALF_W'(32);
    localparam logic [HALF_W-1:0] HALF_COARSE = HALF_W'(16);

    // frequency reset values, hundredths of Hz
    localparam logic [FREQ_W-1:0] FREQ_RESET = FREQ_W'(64'd2000000);
    localparam logic [FREQ_W-1:0] LOW_RESET  = FREQ_W'(64'd1000);
    localparam logic [FREQ_W-1:0] HIGH_RESET = FREQ_W'(64'd8000000000);

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_LIMIT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_LIMIT = 1'b1;

    // accuracy levels
    localparam logic [LEVEL_W-1:0] LVL_XFINE   = 3'd0;
    localparam logic [LEVEL_W-1:0] LVL_FINE    = 3'd1;
    localparam logic [LEVEL_W-1:0] LVL_MEDIUM  = 3'd2;
    localparam logic [LEVEL_W-1:0] LVL_COARSE  = 3'd3;
    localparam logic [LEVEL_W-1:0] LVL_XCOARSE = 3'd4;

    // input request payload
    typedef struct packed {
        logic [COUNT_W-1:0] count_value;
        logic [TIME_W-1:0]  now_ms;
        logic               counting_down;
    } t_aeft_in;

    // result payload
    typedef struct packed {
        logic               changed;
        logic [COUNT_W-1:0] step_count;
        logic [LEVEL_W-1:0] accuracy_level;
        logic [FREQ_W-1:0]  tuned_frequency;
    } t_aeft_out;

    // faster turning (smaller average) gives a coarser level
    function automatic logic [LEVEL_W-1:0] level_from_half(input logic [HALF_W-1:0] half);
        logic [LEVEL_W-1:0] lvl;
        if (half > HALF_XFINE) begin
            lvl = LVL_XFINE;
        end else if (half > HALF_FINE) begin
            lvl = LVL_FINE;
        end else if (half > HALF_MEDIUM) begin
            lvl = LVL_MEDIUM;
        end else if (half > HALF_COARSE) begin
            lvl = LVL_COARSE;
        end else begin
            lvl = LVL_XCOARSE;
        end
        return lvl;
    endfunction

    // step size per level, one bit wider than the frequency
    function automatic logic [FREQ_W:0] step_of(input logic [LEVEL_W-1:0] lvl);
        logic [FREQ_W:0] s;
        case (lvl)
            LVL_XFINE:  s = (FREQ_W+1)'(1) << 1;
            LVL_FINE:   s = (FREQ_W+1)'(1) << 5;
            LVL_MEDIUM: s = (FREQ_W+1)'(1) << 9;
            LVL_COARSE: s = (FREQ_W+1)'(1) << 13;
            default:    s = (FREQ_W+1)'(1) << 17;
        endcase
        return s;
    endfunction

endpackage

// ===== rtl/adaptive_encoder_frequency_tuner_unit.sv =====
// ----------------------------------------------------------------------------
// adaptive_encoder_frequency_tuner_unit
// Takes one encoder capture request per cycle unless stalled and returns one
// result with the count delta, accuracy level and tuned frequency.
// ----------------------------------------------------------------------------
// The unit accepts one request every clock cycle and returns its result in the
// next cycle from an output register; a request is taken whenever that
// register is empty or being read in the same cycle. The figure is set by the
// tuning state (last count, last time, step-time average, level, frequency),
// read and rewritten as each request is taken. A request whose count equals
// the last one leaves the state alone and reports it with changed low and a
// zero step count. The user must write limits through the configuration port
// only while no request is in flight; the block itself does not enforce this.
module adaptive_encoder_frequency_tuner_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration writes
    input  logic                           i_cfg_we,
    input  logic [aeft_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [aeft_pkg::FREQ_W-1:0]    i_cfg_data,
    // capture requests
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  aeft_pkg::t_aeft_in             i_in_data,
    // results
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output aeft_pkg::t_aeft_out            o_out_data
);
    import aeft_pkg::*;

    logic [FREQ_W-1:0]  r_low_limit;
    logic [FREQ_W-1:0]  r_high_limit;
    logic [COUNT_W-1:0] r_prev_count;
    logic [TIME_W-1:0]  r_prev_time;
    logic [AVG_W-1:0]   r_avg;
    logic [LEVEL_W-1:0] r_level;
    logic [FREQ_W-1:0]  r_freq;
    logic               r_out_valid;
    t_aeft_out          r_out_data;

    logic [AVG_W-1:0]   n_avg;
    logic [LEVEL_W-1:0] n_level;
    logic [FREQ_W-1:0]  n_freq;

    logic               in_fire;
    logic               changed;
    logic [TIME_W-1:0]  elapsed;
    logic [HALF_W-1:0]  half;
    logic [COUNT_W-1:0] delta;
    logic [FREQ_W-1:0]  stepped_freq;
    t_aeft_out          result;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // speed estimate and accuracy level
    always_comb begin
        changed = (i_in_data.count_value != r_prev_count);
        elapsed = i_in_data.now_ms - r_prev_time;
        half    = r_avg[AVG_W-1:1];
        n_avg   = r_avg;
        n_level = r_level;
        if (changed) begin
            if (elapsed < TIME_CAP) begin
                n_avg   = r_avg - {1'b0, half} + elapsed[AVG_W-1:0];
                n_level = level_from_half(half);
            end else if (r_level > LVL_FINE) begin
                n_level = LVL_FINE;
                n_avg   = AVG_SLOW;
            end
        end
    end

    // count delta in the turning direction
    always_comb begin
        if (!i_in_data.counting_down) begin
            if (i_in_data.count_value > r_prev_count) begin
                delta = i_in_data.count_value - r_prev_count;
            end else begin
                delta = COUNT_MOD_LOW + i_in_data.count_value - r_prev_count;
            end
        end else begin
            if (i_in_data.count_value < r_prev_count) begin
                delta = r_prev_count - i_in_data.count_value;
            end else begin
                delta = COUNT_MOD_LOW + r_prev_count - i_in_data.count_value;
            end
        end
    end

    // frequency step with limit snap
    aeft_freq_step u_freq_step (
        .i_freq       (r_freq),
        .i_level      (n_level),
        .i_down       (i_in_data.counting_down),
        .i_low_limit  (r_low_limit),
        .i_high_limit (r_high_limit),
        .o_freq       (stepped_freq)
    );

    assign n_freq = changed ? stepped_freq : r_freq;

    // result assembly
    always_comb begin
        result.changed         = changed;
        result.step_count      = changed ? delta : '0;
        result.accuracy_level  = n_level;
        result.tuned_frequency = n_freq;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_limit  <= LOW_RESET;
            r_high_limit <= HIGH_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_LOW_LIMIT:  r_low_limit  <= i_cfg_data;
                REG_HIGH_LIMIT: r_high_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // tuning state, updated only on a changed count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_count <= '0;
            r_prev_time  <= '0;
            r_avg        <= AVG_RESET;
            r_level      <= LVL_XFINE;
            r_freq       <= FREQ_RESET;
        end else if (in_fire && changed) begin
            r_prev_count <= i_in_data.count_value;
            r_prev_time  <= i_in_data.now_ms;
            r_avg        <= n_avg;
            r_level      <= n_level;
            r_freq       <= n_freq;
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out_data <= result;
        end
    end

endmodule

// ===== rtl/aeft_freq_step.sv =====
// ----------------------------------------------------------------------------
// aeft_freq_step
// Moves the frequency by one level-dependent step and snaps any result
// outside the limits to the low limit.
// ----------------------------------------------------------------------------
module aeft_freq_step (
    input  logic [aeft_pkg::FREQ_W-1:0]  i_freq,
    input  logic [aeft_pkg::LEVEL_W-1:0] i_level,
    input  logic                         i_down,
    input  logic [aeft_pkg::FREQ_W-1:0]  i_low_limit,
    input  logic [aeft_pkg::FREQ_W-1:0]  i_high_limit,
    output logic [aeft_pkg::FREQ_W-1:0]  o_freq
);
    import aeft_pkg::*;

    logic [FREQ_W:0] step;
    logic [FREQ_W:0] freq_ext;
    logic [FREQ_W:0] cand;
    logic            under;
    logic            bad;

    // one add or subtract, then a window compare
    always_comb begin
        step     = step_of(i_level);
        freq_ext = {1'b0, i_freq};
        under    = 1'b0;
        if (!i_down) begin
            cand = freq_ext + step;
        end else begin
            under = (freq_ext < step);
            cand  = freq_ext - step;
        end
        bad = under
            || (cand < {1'b0, i_low_limit})
            || (cand > {1'b0, i_high_limit});
        o_freq = bad ? i_low_limit : cand[FREQ_W-1:0];
    end

endmodule

// ===== rtl/aeft_checker.sv =====
// ----------------------------------------------------------------------------
// aeft_checker
// Port-level checks for the encoder frequency tuner, bound to the top level.
// ----------------------------------------------------------------------------
module aeft_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input aeft_pkg::t_aeft_out o_out_data
);
    import aeft_pkg::*;

    // a pending result holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("result dropped or changed while stalled");

    // every accepted request yields a result next cycle
    a_in_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> o_out_valid)
        else $error("accepted request produced no result");

    // a changed count always has a nonzero delta, an unchanged one a zero delta
    a_changed_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.changed == (o_out_data.step_count != '0)))
        else $error("step count disagrees with changed flag");

    // level stays within the five defined steps
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.accuracy_level <= LVL_XCOARSE))
        else $error("accuracy level out of range");

endmodule

bind adaptive_encoder_frequency_tuner_unit aeft_checker u_aeft_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
